// File: hdl/stm_pkg.sv
// shared types and constants for the sensor threshold shutdown monitor
// depends on nothing; imported by every module of the block
`default_nettype none

package stm_pkg;

  localparam int TEMP_CHANNELS = 3;
  localparam int VOLT_CHANNELS = 6;

  localparam int TEMP_W     = 8;
  localparam int VOLT_W     = 15;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 8;
  localparam int NOM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // deviation magnitude and scaled compare widths
  localparam int DEV_W    = VOLT_W + 2;
  localparam int MAG_W    = VOLT_W;
  localparam int SCALED_W = MAG_W + PCT_W;
  localparam int LIM_W    = NOM_W + PCT_W;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

  // rail nominals in millivolts
  localparam logic [NOM_W-1:0] NOMINAL_MV [VOLT_CHANNELS] = '{
    NOM_W'(12000), NOM_W'(5000), NOM_W'(3300),
    NOM_W'(810), NOM_W'(810), NOM_W'(1200)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_ALARM_HIGH    = 3'd0,
    REG_TEMP_ALARM_LOW     = 3'd1,
    REG_TEMP_SHUTDOWN_HIGH = 3'd2,
    REG_TEMP_SHUTDOWN_LOW  = 3'd3,
    REG_VOLT_ALARM_PCT     = 3'd4,
    REG_VOLT_SHUTDOWN_PCT  = 3'd5,
    REG_PERSIST_ROUNDS     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } alarm_ev_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] warn_hi;
    logic signed [TEMP_W-1:0] warn_lo;
    logic signed [TEMP_W-1:0] trip_hi;
    logic signed [TEMP_W-1:0] trip_lo;
    logic [PCT_W-1:0]         warn_pct;
    logic [PCT_W-1:0]         trip_pct;
    logic [CNT_W-1:0]         persist_rounds;
  } cfg_t;

  typedef struct packed {
    logic t_warn;
    logic t_trip;
    logic v_warn;
    logic v_trip;
  } chk_flags_t;

  typedef struct packed {
    alarm_ev_t alarm_event;
    logic      alarm_on;
    logic      temp_over;
    logic      volt_over;
    logic      shut_now;
    logic      shut_held;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/sensor_threshold_shutdown_monitor_top.sv
// top level of the sensor threshold shutdown monitor
// depends on stm_pkg, stm_cfg, stm_check and stm_ctrl
`default_nettype none

// usage
//   input channel (in_valid/in_ready): one item per round; mode 0 checks three
//   temperatures (masked by temp_present) and six rail voltages, mode 1 clears
//   the shutdown latch and both persistence counters
//   output channel (out_valid/out_ready): one result item per input item, in order
//   configuration channel (cfg_valid/cfg_ready): cfg_index picks the register,
//   cfg_data carries the value; cfg_ready is always high, unknown indices are
//   dropped; write only while no item is in flight
// timing
//   an item waits in the input register while the compares and the
//   state update run; out_valid rises when the result register loads it, and
//   the result holds there until out_ready takes it
//   one item per cycle sustained while out_ready stays high, since the alarm
//   flag, counters and latch update together with the result register
// reset: synchronous, both stages empty, alarm, counters and latch cleared,
//   registers back to their defaults
// stalls: with out_ready low the result holds; the input register still takes
//   one more item, then in_ready drops until the result is taken

module sensor_threshold_shutdown_monitor_top
  import stm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic signed [TEMP_W-1:0] temp_a,
  input  logic signed [TEMP_W-1:0] temp_b,
  input  logic signed [TEMP_W-1:0] temp_c,
  input  logic [TEMP_CHANNELS-1:0] temp_present,
  input  logic [VOLT_W-1:0]        volt_12v,
  input  logic [VOLT_W-1:0]        volt_5v,
  input  logic [VOLT_W-1:0]        volt_3v3,
  input  logic [VOLT_W-1:0]        volt_0v81_first,
  input  logic [VOLT_W-1:0]        volt_0v81_second,
  input  logic [VOLT_W-1:0]        volt_1v2,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               alarm_event,
  output logic                     alarm_on,
  output logic                     temp_over_shutdown,
  output logic                     volt_over_shutdown,
  output logic                     shutdown_now,
  output logic                     shutdown_held,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t                     cfg;
  chk_flags_t               flags;
  result_t                  res;
  logic                     out_free;

  // input register
  logic                     s1_valid;
  logic                     s1_mode;
  logic signed [TEMP_W-1:0] s1_temp [TEMP_CHANNELS];
  logic [TEMP_CHANNELS-1:0] s1_present;
  logic [VOLT_W-1:0]        s1_volt [VOLT_CHANNELS];
  logic                     in_take;

  assign cfg_ready = 1'b1;
  // the input stage is ready when empty or when its item moves on to the result register
  assign in_ready  = !s1_valid || out_free;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode    <= mode;
      s1_temp[0] <= temp_a;
      s1_temp[1] <= temp_b;
      s1_temp[2] <= temp_c;
      s1_present <= temp_present;
      s1_volt[0] <= volt_12v;
      s1_volt[1] <= volt_5v;
      s1_volt[2] <= volt_3v3;
      s1_volt[3] <= volt_0v81_first;
      s1_volt[4] <= volt_0v81_second;
      s1_volt[5] <= volt_1v2;
    end
  end

  stm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  stm_check u_check (
    .cfg     (cfg),
    .temp    (s1_temp),
    .present (s1_present),
    .volt    (s1_volt),
    .flags   (flags)
  );

  stm_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (s1_valid),
    .item_clear     (s1_mode),
    .flags          (flags),
    .persist_rounds (cfg.persist_rounds),
    .out_ready      (out_ready),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .res            (res)
  );

  assign alarm_event        = res.alarm_event;
  assign alarm_on           = res.alarm_on;
  assign temp_over_shutdown = res.temp_over;
  assign volt_over_shutdown = res.volt_over;
  assign shutdown_now       = res.shut_now;
  assign shutdown_held      = res.shut_held;

  // both stages come out of reset empty
  a_reset_empty : assert property (@(posedge clk) rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  // no item taken while both stages are full and the result is stalled
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted into a blocked pipeline");

  // a raised event leaves the alarm on, a cleared one leaves it off
  a_event_state : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((alarm_event != EV_RAISED || alarm_on) &&
                   (alarm_event != EV_CLEARED || !alarm_on)))
    else $error("alarm event disagrees with alarm state");

  // a trip pulse always comes with the latch set
  a_trip_latched : assert property (@(posedge clk) disable iff (rst)
    (out_valid && shutdown_now) |-> shutdown_held)
    else $error("shutdown pulse without latch");

endmodule

`default_nettype wire

// File: hdl/stm_cfg.sv
// configuration register file of the monitor
// depends on stm_pkg
`default_nettype none

module stm_cfg
  import stm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_hi        <= TEMP_W'(85);
      cfg.warn_lo        <= -TEMP_W'(20);
      cfg.trip_hi        <= TEMP_W'(100);
      cfg.trip_lo        <= -TEMP_W'(40);
      cfg.warn_pct       <= PCT_W'(5);
      cfg.trip_pct       <= PCT_W'(10);
      cfg.persist_rounds <= CNT_W'(3);
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_TEMP_ALARM_HIGH:    cfg.warn_hi        <= wr_data[TEMP_W-1:0];
        REG_TEMP_ALARM_LOW:     cfg.warn_lo        <= wr_data[TEMP_W-1:0];
        REG_TEMP_SHUTDOWN_HIGH: cfg.trip_hi        <= wr_data[TEMP_W-1:0];
        REG_TEMP_SHUTDOWN_LOW:  cfg.trip_lo        <= wr_data[TEMP_W-1:0];
        REG_VOLT_ALARM_PCT:     cfg.warn_pct       <= wr_data[PCT_W-1:0];
        REG_VOLT_SHUTDOWN_PCT:  cfg.trip_pct       <= wr_data[PCT_W-1:0];
        REG_PERSIST_ROUNDS:     cfg.persist_rounds <= wr_data[CNT_W-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/stm_check.sv
// window and band compares for one round of samples
// depends on stm_pkg
`default_nettype none

module stm_check
  import stm_pkg::*;
(
  input  cfg_t                     cfg,
  input  logic signed [TEMP_W-1:0] temp [TEMP_CHANNELS],
  input  logic [TEMP_CHANNELS-1:0] present,
  input  logic [VOLT_W-1:0]        volt [VOLT_CHANNELS],
  output chk_flags_t               flags
);

  logic [TEMP_CHANNELS-1:0] t_al_hit, t_sd_hit;
  logic [VOLT_CHANNELS-1:0] v_al_hit, v_sd_hit;

  for (genvar j = 0; j < TEMP_CHANNELS; j++) begin : g_temp
    always_comb begin
      t_al_hit[j] = present[j] && ((temp[j] > $signed(cfg.warn_hi)) ||
                                   (temp[j] < $signed(cfg.warn_lo)));
      t_sd_hit[j] = present[j] && ((temp[j] > $signed(cfg.trip_hi)) ||
                                   (temp[j] < $signed(cfg.trip_lo)));
    end
  end

  // v outside nom +- floor(nom*pct/100)  <=>  100*|v - nom| > nom*pct
  for (genvar i = 0; i < VOLT_CHANNELS; i++) begin : g_volt
    logic signed [DEV_W-1:0] dev;
    logic [MAG_W-1:0]        mag;
    logic [SCALED_W-1:0]     scaled;
    logic [LIM_W-1:0]        lim_al, lim_sd;

    always_comb begin
      dev    = $signed({2'b00, volt[i]}) - $signed({3'b000, NOMINAL_MV[i]});
      mag    = dev[DEV_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
      scaled = SCALED_W'(mag) * SCALED_W'(PCT_SCALE);
      lim_al = LIM_W'(NOMINAL_MV[i]) * LIM_W'(cfg.warn_pct);
      lim_sd = LIM_W'(NOMINAL_MV[i]) * LIM_W'(cfg.trip_pct);
      v_al_hit[i] = scaled > SCALED_W'(lim_al);
      v_sd_hit[i] = scaled > SCALED_W'(lim_sd);
    end
  end

  assign flags.t_warn = |t_al_hit;
  assign flags.t_trip = |t_sd_hit;
  assign flags.v_warn = |v_al_hit;
  assign flags.v_trip = |v_sd_hit;

endmodule

`default_nettype wire

// File: hdl/stm_ctrl.sv
// alarm state, persistence counters, shutdown latch and result register
// depends on stm_pkg
`default_nettype none

module stm_ctrl
  import stm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_clear,
  input  chk_flags_t       flags,
  input  logic [CNT_W-1:0] persist_rounds,
  input  logic             out_ready,
  output logic             out_free,
  output logic             out_valid,
  output result_t          res
);

  logic             alarm_flag, alarm_flag_next;
  logic [CNT_W-1:0] temp_cnt, temp_cnt_next;
  logic [CNT_W-1:0] volt_cnt, volt_cnt_next;
  logic             latch, latch_next;
  result_t          res_next;
  logic             warn_any;
  logic             load;

  assign out_free = !out_valid || out_ready;
  assign load     = item_valid && out_free;

  always_comb begin
    alarm_flag_next = alarm_flag;
    temp_cnt_next   = temp_cnt;
    volt_cnt_next   = volt_cnt;
    latch_next      = latch;
    warn_any        = flags.t_warn || flags.v_warn;
    res_next        = '{alarm_event: EV_NONE, alarm_on: 1'b0, temp_over: 1'b0,
                        volt_over: 1'b0, shut_now: 1'b0, shut_held: 1'b0};

    if (item_clear) begin
      latch_next    = 1'b0;
      temp_cnt_next = '0;
      volt_cnt_next = '0;
    end else if (!latch) begin
      if (warn_any != alarm_flag) begin
        res_next.alarm_event = warn_any ? EV_RAISED : EV_CLEARED;
        alarm_flag_next      = warn_any;
      end
      if (flags.t_trip) begin
        temp_cnt_next = (temp_cnt == CNT_MAX) ? temp_cnt : temp_cnt + 1'b1;
      end else begin
        temp_cnt_next = '0;
      end
      if (flags.v_trip) begin
        volt_cnt_next = (volt_cnt == CNT_MAX) ? volt_cnt : volt_cnt + 1'b1;
      end else begin
        volt_cnt_next = '0;
      end
      if ((temp_cnt_next >= persist_rounds) || (volt_cnt_next >= persist_rounds)) begin
        latch_next        = 1'b1;
        res_next.shut_now = 1'b1;
      end
      res_next.temp_over = flags.t_trip;
      res_next.volt_over = flags.v_trip;
    end

    res_next.alarm_on  = alarm_flag_next;
    res_next.shut_held = latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_flag <= 1'b0;
      temp_cnt   <= '0;
      volt_cnt   <= '0;
      latch      <= 1'b0;
      out_valid  <= 1'b0;
    end else if (load) begin
      alarm_flag <= alarm_flag_next;
      temp_cnt   <= temp_cnt_next;
      volt_cnt   <= volt_cnt_next;
      latch      <= latch_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
